// File: rtl/core/sthq_pkg.sv
package sthq_pkg;

    // item layouts on the two channels
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               surface_present;
        logic        [9:0]  base_height;
        logic        [9:0]  water_level;
        logic        [3:0]  corner_bits;
        logic               double_height;
    } query_t;

    typedef struct packed {
        logic [10:0] land_height;
        logic [9:0]  water_height;
    } result_t;

    // sub-tile geometry
    localparam int SUB_BITS = 5;
    localparam logic signed [7:0] SUB_MAX = 8'sd31;
    localparam logic [10:0] DEFAULT_LAND = 11'd16;

    // raised-corner patterns (bit0 north, bit1 east, bit2 south, bit3 west)
    localparam logic [3:0] SLOPE_FLAT      = 4'd0;
    localparam logic [3:0] SLOPE_N         = 4'd1;
    localparam logic [3:0] SLOPE_E         = 4'd2;
    localparam logic [3:0] SLOPE_S         = 4'd4;
    localparam logic [3:0] SLOPE_W         = 4'd8;
    localparam logic [3:0] SLOPE_NE        = 4'd3;
    localparam logic [3:0] SLOPE_ES        = 4'd6;
    localparam logic [3:0] SLOPE_NW        = 4'd9;
    localparam logic [3:0] SLOPE_SW        = 4'd12;
    localparam logic [3:0] SLOPE_W_DOWN    = 4'd7;
    localparam logic [3:0] SLOPE_S_DOWN    = 4'd11;
    localparam logic [3:0] SLOPE_E_DOWN    = 4'd13;
    localparam logic [3:0] SLOPE_N_DOWN    = 4'd14;
    localparam logic [3:0] SLOPE_NS_VALLEY = 4'd5;
    localparam logic [3:0] SLOPE_WE_VALLEY = 4'd10;
    localparam logic [3:0] SLOPE_ALL_UP    = 4'd15;

    // halve, truncating toward zero
    function automatic logic signed [7:0] half_tz(input logic signed [7:0] v);
        logic signed [7:0] adj;
        adj = v + {7'd0, v[7]};
        return adj >>> 1;
    endfunction

    // halve the positive part, zero otherwise
    function automatic logic signed [7:0] pos_half(input logic signed [7:0] v);
        return (v > 8'sd0) ? (v >>> 1) : 8'sd0;
    endfunction

endpackage

// File: rtl/core/sthq_stream_if.sv
interface sthq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/sthq_slope.sv
module sthq_slope (
    input  logic [sthq_pkg::SUB_BITS-1:0] x,
    input  logic [sthq_pkg::SUB_BITS-1:0] y,
    input  logic [3:0]                    corners,
    input  logic                          dbl,
    output logic [5:0]                    term
);
    import sthq_pkg::*;

    logic signed [7:0] sx;
    logic signed [7:0] sy;
    logic signed [7:0] t;

    assign sx = {3'b000, x};
    assign sy = {3'b000, y};

    // slope term by raised-corner pattern
    always_comb
    begin
        case (corners)
            SLOPE_N:  t = pos_half(sx + sy - SUB_MAX);
            SLOPE_E:  t = pos_half(sx - sy);
            SLOPE_S:  t = pos_half(SUB_MAX - sy - sx);
            SLOPE_W:  t = pos_half(sy - sx);
            SLOPE_NE: t = (sx >>> 1) + 8'sd1;
            SLOPE_ES: t = (SUB_MAX - sy) >>> 1;
            SLOPE_NW: t = (sy >>> 1) + 8'sd1;
            SLOPE_SW: t = (SUB_MAX - sx) >>> 1;
            SLOPE_W_DOWN:
                t = dbl ? ((sx + SUB_MAX - sy) >>> 1) + 8'sd1
                        : half_tz(sx - sy) + 8'sd16;
            SLOPE_S_DOWN:
                t = dbl ? ((sx + sy) >>> 1) + 8'sd1
                        : half_tz(sx + sy - SUB_MAX - 8'sd1) + 8'sd16;
            SLOPE_E_DOWN:
                t = dbl ? ((SUB_MAX - sx + sy) >>> 1) + 8'sd1
                        : half_tz(sy - sx) + 8'sd16;
            SLOPE_N_DOWN:
                t = dbl ? (((SUB_MAX - sx) + (SUB_MAX - sy)) >>> 1) + 8'sd1
                        : half_tz(SUB_MAX - sy - sx - 8'sd1) + 8'sd16;
            SLOPE_NS_VALLEY: t = pos_half(sx - sy);
            // flat, west-east valley, all four up
            default:  t = 8'sd0;
        endcase
    end

    assign term = t[5:0];

endmodule

// File: rtl/core/sloped_tile_height_query_core.sv
// channel  | dir | payload
// ---------+-----+----------------------------------------------------------
// query    | in  | pos_x, pos_y, surface_present, base_height, water_level,
//          |     | corner_bits, double_height
// result   | out | land_height, water_height
//
// one query per cycle sustained while result.ready stays high; a query passes
// through the input register, then the result register, before result.valid
// rises for it
// reset clears both stage valid flags; payload registers are not reset
// a stalled result holds in the result register while the input register
// still takes a query, so both stages fill before query.ready drops
module sloped_tile_height_query_core #(
    parameter int MAP_WIDTH  = 12288,
    parameter int MAP_HEIGHT = 12288
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sthq_stream_if.sink          query,
    sthq_stream_if.source        result
);
    import sthq_pkg::*;

    localparam logic [15:0] X_LIMIT = 16'(MAP_WIDTH - 1);
    localparam logic [15:0] Y_LIMIT = 16'(MAP_HEIGHT - 1);

    query_t  q_reg;
    logic    q_valid_reg;
    result_t r_reg;
    result_t r_next;
    logic    r_valid_reg;

    logic       s1_adv;
    logic       off_map;
    logic [5:0] term;

    // stage handshake
    assign s1_adv      = !r_valid_reg || result.ready;
    assign query.ready = !q_valid_reg || s1_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (query.ready)
        begin
            q_valid_reg <= query.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query.valid && query.ready)
        begin
            q_reg <= query.data;
        end
    end

    // map bounds, negative coordinates fail as large unsigned values
    assign off_map = (16'(q_reg.pos_x) >= X_LIMIT) || (16'(q_reg.pos_y) >= Y_LIMIT);

    sthq_slope u_slope (
        .x       (q_reg.pos_x[SUB_BITS-1:0]),
        .y       (q_reg.pos_y[SUB_BITS-1:0]),
        .corners (q_reg.corner_bits),
        .dbl     (q_reg.double_height),
        .term    (term)
    );

    // result forming
    always_comb
    begin
        if (off_map || !q_reg.surface_present)
        begin
            r_next.land_height  = DEFAULT_LAND;
            r_next.water_height = 10'd0;
        end
        else
        begin
            r_next.land_height  = {1'b0, q_reg.base_height} + {5'd0, term};
            r_next.water_height = q_reg.water_level;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            r_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && q_valid_reg)
        begin
            r_reg <= r_next;
        end
    end

    assign result.valid = r_valid_reg;
    assign result.data  = r_reg;

    // a held query moves into the result stage whenever that stage frees up
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg && s1_adv |=> r_valid_reg)
        else $error("held query did not reach the result stage");

    // off-map or bare tiles give the default heights
    a_default_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid_reg && s1_adv && (off_map || !q_reg.surface_present)
        |=> r_reg.land_height == DEFAULT_LAND && r_reg.water_height == 10'd0)
        else $error("default heights not produced");

    // an empty result stage never blocks the query side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid_reg |-> query.ready)
        else $error("query stalled with empty result stage");

    // no transfer overwrites a query that cannot move on
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        query.valid && query.ready |-> !q_valid_reg || s1_adv)
        else $error("held query overwritten");

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sthq_pkg::*;

    localparam int MAP_W        = 12288;
    localparam int MAP_H        = 12288;
    localparam int RANDOM_ITEMS = 800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 60;
    localparam int SQUEEZE_AT   = 200;
    localparam int DRAIN_AT     = 500;

    // answer that off-map and surfaceless tiles give
    localparam result_t GROUND = '{land_height: DEFAULT_LAND, water_height: 10'd0};
    localparam result_t UNUSED = '{land_height: 11'd0, water_height: 10'd0};

    typedef struct {
        query_t  q;
        bit      typed;
        result_t want;
    } probe_t;

    logic clk;
    logic rst_n;

    sthq_stream_if #(.payload_t(query_t))  query_ch ();
    sthq_stream_if #(.payload_t(result_t)) result_ch ();

    sloped_tile_height_query_core #(
        .MAP_WIDTH  (MAP_W),
        .MAP_HEIGHT (MAP_H)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    result_t heights_due[$];
    probe_t  probes[$];
    int      fails;
    int      idle_cycles;
    bit      hold_off_req;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic query_t mk(int x, int y, bit present, int base, int water,
                                  logic [3:0] corners, bit dbl);
        query_t q;
        q.pos_x           = 16'(x);
        q.pos_y           = 16'(y);
        q.surface_present = present;
        q.base_height     = 10'(base);
        q.water_level     = 10'(water);
        q.corner_bits     = corners;
        q.double_height   = dbl;
        return q;
    endfunction

    // half of a rise, zero when the point lies below the raised edge
    function automatic int rise_half(int v);
        return (v > 0) ? v / 2 : 0;
    endfunction

    // land and water height at the queried point
    function automatic result_t tile_height_of(query_t q);
        int      px;
        int      py;
        int      x;
        int      y;
        int      top;
        int      term;
        result_t r;
        px  = int'($signed(q.pos_x));
        py  = int'($signed(q.pos_y));
        top = int'(SUB_MAX);
        if (px < 0 || px >= MAP_W - 1 || py < 0 || py >= MAP_H - 1 || !q.surface_present)
        begin
            return GROUND;
        end
        x = int'(q.pos_x[SUB_BITS-1:0]);
        y = int'(q.pos_y[SUB_BITS-1:0]);
        case (q.corner_bits)
            SLOPE_N:         term = rise_half(x + y - top);
            SLOPE_E:         term = rise_half(x - y);
            SLOPE_S:         term = rise_half(top - x - y);
            SLOPE_W:         term = rise_half(y - x);
            SLOPE_NE:        term = x / 2 + 1;
            SLOPE_ES:        term = (top - y) / 2;
            SLOPE_NW:        term = y / 2 + 1;
            SLOPE_SW:        term = (top - x) / 2;
            SLOPE_W_DOWN:    term = q.double_height ? (x + top - y) / 2 + 1
                                                    : (x - y) / 2 + 16;
            SLOPE_S_DOWN:    term = q.double_height ? (x + y) / 2 + 1
                                                    : (x + y - top - 1) / 2 + 16;
            SLOPE_E_DOWN:    term = q.double_height ? (top - x + y) / 2 + 1
                                                    : (y - x) / 2 + 16;
            SLOPE_N_DOWN:    term = q.double_height ? ((top - x) + (top - y)) / 2 + 1
                                                    : (top - y - x - 1) / 2 + 16;
            SLOPE_NS_VALLEY: term = rise_half(x - y);
            default:         term = 0;
        endcase
        r.land_height  = 11'(int'(q.base_height) + term);
        r.water_height = q.water_level;
        return r;
    endfunction

    // mostly on-map queries, some at the map edge, some anywhere
    function automatic query_t random_query();
        query_t      q;
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom(), $urandom()};
        q    = raw[$bits(query_t)-1:0];
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            q.pos_x = 16'($urandom_range(0, MAP_W - 2));
            q.pos_y = 16'($urandom_range(0, MAP_H - 2));
        end
        else if (pick == 7)
        begin
            q.pos_x = 16'(MAP_W - 3 + $urandom_range(0, 3));
            q.pos_y = 16'($urandom_range(0, 1) ? MAP_H - 2 : $urandom_range(0, 31));
        end
        q.surface_present = ($urandom_range(0, 15) != 0);
        return q;
    endfunction

    // one query transfer, expectation recorded on acceptance
    task automatic offer(query_t q, result_t want);
        @(negedge clk);
        query_ch.valid <= 1'b1;
        query_ch.data  <= q;
        @(posedge clk);
        while (!query_ch.ready)
        begin
            @(posedge clk);
        end
        heights_due = {heights_due, want};
    endtask

    task automatic hold_back(int n);
        repeat (n)
        begin
            @(negedge clk);
            query_ch.valid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        hold_back(1);
        while (heights_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // stimulus
    initial
    begin
        query_t q;
        result_t want;
        int sent;
        int burst;
        int k;
        bit squeezed;
        bit drained;
        fails          = 0;
        hold_off_req   = 1'b0;
        rst_n          = 1'b0;
        query_ch.valid = 1'b0;
        query_ch.data  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed queries: edges of the map, every corner pattern, extreme sub-tile offsets
        probes = '{
            '{mk(-1, 100, 1, 500, 300, SLOPE_FLAT, 0), 1'b1, GROUND},
            '{mk(MAP_W - 1, 100, 1, 500, 300, SLOPE_NE, 0), 1'b1, GROUND},
            '{mk(32767, -32768, 1, 1023, 1023, SLOPE_W_DOWN, 1), 1'b1, GROUND},
            '{mk(200, MAP_H - 1, 1, 12, 34, SLOPE_N, 0), 1'b1, GROUND},
            '{mk(1000, 1000, 0, 1023, 1023, SLOPE_ALL_UP, 1), 1'b1, GROUND},
            '{mk(MAP_W - 2, MAP_H - 2, 1, 1023, 1023, SLOPE_FLAT, 1), 1'b1,
              '{land_height: 11'd1023, water_height: 10'd1023}},
            '{mk(0, 0, 1, 0, 0, SLOPE_ALL_UP, 0), 1'b1,
              '{land_height: 11'd0, water_height: 10'd0}},
            '{mk(351, 320, 1, 700, 5, SLOPE_WE_VALLEY, 0), 1'b1,
              '{land_height: 11'd700, water_height: 10'd5}},
            '{mk(351, 351, 1, 100, 1, SLOPE_N, 0), 1'b0, UNUSED},
            '{mk(351, 320, 1, 100, 2, SLOPE_E, 0), 1'b0, UNUSED},
            '{mk(320, 320, 1, 100, 3, SLOPE_S, 1), 1'b0, UNUSED},
            '{mk(320, 351, 1, 100, 4, SLOPE_W, 0), 1'b0, UNUSED},
            '{mk(351, 330, 1, 100, 5, SLOPE_NE, 0), 1'b0, UNUSED},
            '{mk(333, 320, 1, 100, 6, SLOPE_ES, 0), 1'b0, UNUSED},
            '{mk(340, 351, 1, 100, 7, SLOPE_NW, 0), 1'b0, UNUSED},
            '{mk(320, 345, 1, 100, 8, SLOPE_SW, 1), 1'b0, UNUSED},
            '{mk(320, 351, 1, 200, 9, SLOPE_W_DOWN, 0), 1'b0, UNUSED},
            '{mk(351, 320, 1, 200, 10, SLOPE_W_DOWN, 1), 1'b0, UNUSED},
            '{mk(320, 320, 1, 200, 11, SLOPE_S_DOWN, 0), 1'b0, UNUSED},
            '{mk(351, 351, 1, 200, 12, SLOPE_S_DOWN, 1), 1'b0, UNUSED},
            '{mk(351, 320, 1, 200, 13, SLOPE_E_DOWN, 0), 1'b0, UNUSED},
            '{mk(320, 351, 1, 200, 14, SLOPE_E_DOWN, 1), 1'b0, UNUSED},
            '{mk(351, 351, 1, 200, 15, SLOPE_N_DOWN, 0), 1'b0, UNUSED},
            '{mk(MAP_W - 34, MAP_H - 34, 1, 1023, 16, SLOPE_N_DOWN, 1), 1'b0, UNUSED},
            '{mk(351, 320, 1, 300, 17, SLOPE_NS_VALLEY, 0), 1'b0, UNUSED},
            '{mk(320, 351, 1, 300, 18, SLOPE_NS_VALLEY, 0), 1'b0, UNUSED}
        };
        foreach (probes[i])
        begin
            want = probes[i].typed ? probes[i].want : tile_height_of(probes[i].q);
            offer(probes[i].q, want);
            hold_back($urandom_range(0, 2));
        end

        // random queries in bursts
        sent     = 0;
        squeezed = 1'b0;
        drained  = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 30);
            if (sent >= SQUEEZE_AT && !squeezed)
            begin
                // receiver holds off while queries keep coming
                squeezed     = 1'b1;
                hold_off_req = 1'b1;
                burst        = 30;
            end
            for (k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                q = random_query();
                offer(q, tile_height_of(q));
                sent++;
            end
            if (sent >= DRAIN_AT && !drained)
            begin
                drained = 1'b1;
                wait_drained();
            end
            else
            begin
                hold_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            end
        end

        // let the pipeline empty and catch any stray transfer
        wait_drained();
        repeat (8) @(posedge clk);
        if (fails == 0)
        begin
            $display("PASS sloped_tile_height_query_core");
        end
        else
        begin
            $display("FAIL sloped_tile_height_query_core");
        end
        $finish;
    end

    // result back-pressure in spans of changing character
    initial
    begin
        int mode;
        int span;
        int tick;
        result_ch.ready = 1'b0;
        tick            = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    result_ch.ready <= 1'b0;
                    repeat (LONG_HOLD - 1) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        0:       result_ch.ready <= 1'b1;
                        1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                        2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: result_ch.ready <= (tick % 3 != 0);
                    endcase
                end
            end
        end
    end

    // result comparison and watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (heights_due.size() == 0)
                begin
                    $error("result transfer with nothing expected: %s %0d %s %0d",
                           "land_height", result_ch.data.land_height,
                           "water_height", result_ch.data.water_height);
                    fails++;
                end
                else
                begin
                    want = heights_due.pop_front();
                    if (result_ch.data.land_height !== want.land_height)
                    begin
                        $error("land_height: expected %0d, got %0d",
                               want.land_height, result_ch.data.land_height);
                        fails++;
                    end
                    if (result_ch.data.water_height !== want.water_height)
                    begin
                        $error("water_height: expected %0d, got %0d",
                               want.water_height, result_ch.data.water_height);
                        fails++;
                    end
                end
            end
            if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("FAIL sloped_tile_height_query_core");
                    $finish;
                end
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

endmodule
